/* rtl/mctp_packet_fragmenter_top_assert.svh */
// ----------------------------------------------------------------------------
// MCTP fragmenter assertion macros
// Shared property forms for the port-level checks of the fragmenter.
// ----------------------------------------------------------------------------
`ifndef MCTP_PACKET_FRAGMENTER_TOP_ASSERT_SVH
`define MCTP_PACKET_FRAGMENTER_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define MPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpf assertion failed");

// Next-cycle implication, ignored while reset is held.
`define MPF_ASSERT_NXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpf assertion failed");

// Next-cycle implication that is also checked across reset.
`define MPF_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mpf assertion failed");

`endif

/* rtl/mpf_pkg.sv */
// ----------------------------------------------------------------------------
// MCTP fragmenter package
// Types and constants shared by the fragmenter modules.
// ----------------------------------------------------------------------------
package mpf_pkg;

    localparam int HDR_BYTES  = 4;
    localparam int LEN_W      = 13;
    localparam int MP_W       = 8;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 8;
    localparam int M_USER_W   = 2;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam logic [MP_W-1:0] MP_RESET = 8'd64;

    // Output beat position within one job.
    localparam logic [2:0] STEP_HDR0 = 3'd0;
    localparam logic [2:0] STEP_HDR1 = 3'd1;
    localparam logic [2:0] STEP_HDR2 = 3'd2;
    localparam logic [2:0] STEP_HDR3 = 3'd3;
    localparam logic [2:0] STEP_DATA = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       has_hdr;
        logic [7:0] hdr0;
        logic [7:0] hdr1;
        logic [7:0] hdr2;
        logic [7:0] hdr3;
    } t_job;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

/* rtl/mpf_front.sv */
// ----------------------------------------------------------------------------
// MCTP fragmenter front end
// Takes message bytes, stores the header and turns each payload byte into a
// job that says whether a header copy goes ahead of it.
// ----------------------------------------------------------------------------
module mpf_front #(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_first_byte,
    input  logic [mpf_pkg::LEN_W-1:0]    i_msg_length,
    input  logic                         i_cfg_wr_en,
    input  logic [mpf_pkg::MP_W-1:0]     i_cfg_wr_data,
    output logic                         o_push,
    output mpf_pkg::t_job                o_job
);

    localparam logic [mpf_pkg::LEN_W:0] MAX_LEN_W = (mpf_pkg::LEN_W+1)'(MAX_PAYLOAD_BYTES);
    localparam logic [mpf_pkg::LEN_W-1:0] HDR_W = mpf_pkg::LEN_W'(mpf_pkg::HDR_BYTES);

    logic [7:0]                  r_hdr [mpf_pkg::HDR_BYTES];
    logic [mpf_pkg::LEN_W-1:0]   r_pos, n_pos;
    logic [mpf_pkg::LEN_W-1:0]   r_total, n_total;
    logic [7:0]                  r_fill, n_fill;
    logic [1:0]                  r_seq, n_seq;
    logic                        r_first_pkt, n_first_pkt;
    logic                        r_in_msg, n_in_msg;
    logic [mpf_pkg::MP_W-1:0]    r_mp;

    logic [mpf_pkg::MP_W-1:0]    mp_eff;
    logic                        len_ok;
    logic [mpf_pkg::LEN_W-1:0]   s_pos, s_total;
    logic [7:0]                  s_fill;
    logic [1:0]                  s_seq;
    logic                        s_first_pkt, s_in_msg;
    logic                        is_hdr;
    logic                        msg_end, pkt_end, eom;
    logic [mpf_pkg::LEN_W:0]     remaining;
    logic [8:0]                  fill_inc;

    always_comb begin
        mp_eff = (r_mp == '0) ? mpf_pkg::MP_W'(1) : r_mp;
        len_ok = (i_msg_length > HDR_W) &&
                 (({1'b0, i_msg_length} - {1'b0, HDR_W}) <= MAX_LEN_W);

        if (i_first_byte) begin
            s_pos       = '0;
            s_total     = len_ok ? (i_msg_length - HDR_W) : '0;
            s_fill      = '0;
            s_seq       = '0;
            s_first_pkt = 1'b1;
            s_in_msg    = len_ok;
        end else begin
            s_pos       = r_pos;
            s_total     = r_total;
            s_fill      = r_fill;
            s_seq       = r_seq;
            s_first_pkt = r_first_pkt;
            s_in_msg    = r_in_msg;
        end

        is_hdr    = s_pos < HDR_W;
        msg_end   = ({1'b0, s_pos} - (mpf_pkg::LEN_W+1)'(mpf_pkg::HDR_BYTES - 1))
                    >= {1'b0, s_total};
        remaining = {1'b0, s_total} + {1'b0, HDR_W} - {1'b0, s_pos};
        eom       = remaining <= (mpf_pkg::LEN_W+1)'(mp_eff);
        fill_inc  = {1'b0, s_fill} + 9'd1;
        pkt_end   = msg_end || (fill_inc >= {1'b0, mp_eff});

        o_push        = i_accept && s_in_msg && !is_hdr;
        o_job.data    = i_data_byte;
        o_job.pkt_end = pkt_end;
        o_job.has_hdr = (s_fill == '0);
        o_job.hdr0    = r_hdr[0];
        o_job.hdr1    = r_hdr[1];
        o_job.hdr2    = r_hdr[2];
        o_job.hdr3    = {s_first_pkt, eom, s_seq, r_hdr[3][3:0]};

        n_pos       = s_pos;
        n_total     = s_total;
        n_fill      = s_fill;
        n_seq       = s_seq;
        n_first_pkt = s_first_pkt;
        n_in_msg    = s_in_msg;
        if (s_in_msg) begin
            n_pos = s_pos + mpf_pkg::LEN_W'(1);
            if (!is_hdr) begin
                if (pkt_end) begin
                    n_fill      = '0;
                    n_seq       = s_seq + 2'd1;
                    n_first_pkt = 1'b0;
                end else begin
                    n_fill = fill_inc[7:0];
                end
                if (msg_end) begin
                    n_in_msg = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_total     <= '0;
            r_fill      <= '0;
            r_seq       <= '0;
            r_first_pkt <= 1'b1;
            r_in_msg    <= 1'b0;
            r_mp        <= mpf_pkg::MP_RESET;
        end else begin
            if (i_accept) begin
                r_pos       <= n_pos;
                r_total     <= n_total;
                r_fill      <= n_fill;
                r_seq       <= n_seq;
                r_first_pkt <= n_first_pkt;
                r_in_msg    <= n_in_msg;
            end
            if (i_cfg_wr_en) begin
                r_mp <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && s_in_msg && is_hdr) begin
            r_hdr[s_pos[1:0]] <= i_data_byte;
        end
    end

endmodule

/* rtl/mpf_queue.sv */
// ----------------------------------------------------------------------------
// MCTP fragmenter job queue
// Short first-in first-out buffer of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module mpf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mpf_pkg::t_job        i_job,
    input  logic                 i_pop,
    output mpf_pkg::t_job        o_head,
    output mpf_pkg::t_q_status   o_status
);

    mpf_pkg::t_job               r_mem [mpf_pkg::Q_DEPTH];
    logic [mpf_pkg::Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [mpf_pkg::Q_CNT_W-1:0] r_count, n_count;
    logic                        do_push, do_pop;

    always_comb begin
        o_status.full  = (r_count == mpf_pkg::Q_CNT_W'(mpf_pkg::Q_DEPTH));
        o_status.valid = (r_count != '0);
        do_push        = i_push && !o_status.full;
        do_pop         = i_pop && o_status.valid;
        o_head         = r_mem[r_rptr];
        n_count        = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + mpf_pkg::Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - mpf_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= r_wptr + mpf_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + mpf_pkg::Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

/* rtl/mpf_back.sv */
// ----------------------------------------------------------------------------
// MCTP fragmenter back end
// Expands each job into its payload byte, led by a header copy when has_hdr
// is set; one beat per cycle unless stalled, via a registered output stage.
// ----------------------------------------------------------------------------
module mpf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpf_pkg::t_job        i_head,
    input  mpf_pkg::t_q_status   i_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_byte,
    output logic                 o_start,
    output logic                 o_end,
    output logic                 o_last
);

    logic [2:0] r_step;
    logic [2:0] step;
    logic       advance;
    logic [7:0] beat_byte;
    logic       beat_start, beat_end, beat_last;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_start, r_end, r_last;

    always_comb begin
        step       = i_head.has_hdr ? r_step : mpf_pkg::STEP_DATA;
        advance    = i_status.valid && (!r_valid || i_ready);
        beat_byte  = i_head.data;
        beat_start = 1'b0;
        beat_end   = 1'b0;
        beat_last  = 1'b0;
        case (step)
            mpf_pkg::STEP_HDR0: begin
                beat_byte  = i_head.hdr0;
                beat_start = 1'b1;
            end
            mpf_pkg::STEP_HDR1: beat_byte = i_head.hdr1;
            mpf_pkg::STEP_HDR2: beat_byte = i_head.hdr2;
            mpf_pkg::STEP_HDR3: beat_byte = i_head.hdr3;
            default: begin
                beat_byte = i_head.data;
                beat_end  = i_head.pkt_end;
                beat_last = 1'b1;
            end
        endcase
        o_pop = advance && (step == mpf_pkg::STEP_DATA);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= mpf_pkg::STEP_HDR0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step <= (step == mpf_pkg::STEP_DATA) ? mpf_pkg::STEP_HDR0
                                                       : r_step + 3'd1;
            end
            if (!r_valid || i_ready) begin
                r_valid <= i_status.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte  <= beat_byte;
            r_start <= beat_start;
            r_end   <= beat_end;
            r_last  <= beat_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_last  = r_last;

endmodule

/* rtl/mctp_packet_fragmenter_top.sv */
// ----------------------------------------------------------------------------
// MCTP packet fragmenter
// Splits one MCTP message into packets, each led by a copy of the header.
//
//   Channel  Dir  Beat contents
//   s_axis   in   tdata[7:0] data_byte, tdata[20:8] msg_length, tuser first_byte
//   m_axis   out  tdata out_byte, tuser[0] packet_start, tuser[1] packet_end,
//                 tlast run_last
//   cfg      in   wr_data payload limit, written when wr_en is high
//
// One input byte is taken per cycle while the job queue has room.
// The output side sends one beat per cycle unless stalled: a payload byte that
// opens a packet costs five beats, any other payload byte one, header bytes none.
// The four-entry job queue lets either side stall without stopping the other.
// Reset is synchronous and active low; the payload limit returns to 64.
// ----------------------------------------------------------------------------
module mctp_packet_fragmenter_top #(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] data_byte, [20:8] msg_length, [23:21] zero
    input  logic [mpf_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [0] first_byte
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] out_byte
    output logic [mpf_pkg::M_DATA_W-1:0]   o_m_tdata,
    // [0] packet_start, [1] packet_end
    output logic [mpf_pkg::M_USER_W-1:0]   o_m_tuser,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_wr_en,
    input  logic [mpf_pkg::MP_W-1:0]       i_cfg_wr_data
);

    logic                 accept;
    logic                 push;
    logic                 pop;
    mpf_pkg::t_job        job;
    mpf_pkg::t_job        head;
    mpf_pkg::t_q_status   q_status;
    logic                 beat_start, beat_end;

    assign o_s_tready = !q_status.full;
    assign accept     = i_s_tvalid && o_s_tready;

    mpf_front #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_s_tdata[7:0]),
        .i_first_byte  (i_s_tuser),
        .i_msg_length  (i_s_tdata[20:8]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (push),
        .o_job         (job)
    );

    mpf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    mpf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_status),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_byte   (o_m_tdata),
        .o_start  (beat_start),
        .o_end    (beat_end),
        .o_last   (o_m_tlast)
    );

    assign o_m_tuser = {beat_end, beat_start};

endmodule

/* rtl/mpf_checker.sv */
// ----------------------------------------------------------------------------
// MCTP fragmenter port checker
// Watches the output stream of the fragmenter for beat ordering slips.
// ----------------------------------------------------------------------------
`include "mctp_packet_fragmenter_top_assert.svh"

module mpf_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [mpf_pkg::M_DATA_W-1:0]   o_m_tdata,
    input  logic [mpf_pkg::M_USER_W-1:0]   o_m_tuser,
    input  logic                           o_m_tlast
);

    `MPF_ASSERT_NXT(a_out_hold, i_clk, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), i_rst_n)
    `MPF_ASSERT_IMP(a_start_not_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], !o_m_tlast && !o_m_tuser[1])
    `MPF_ASSERT_IMP(a_end_on_data, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1], o_m_tlast)
    `MPF_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind mctp_packet_fragmenter_top mpf_checker u_mpf_checker (.*);

/* tb/mctp_packet_fragmenter_checker.sv */
// ----------------------------------------------------------------------------
// MCTP fragmenter checker
// Watches the input, output and register ports of the fragmenter. It predicts
// the packet beats from every accepted input beat and compares each output
// beat with the oldest prediction.
// ----------------------------------------------------------------------------
module mctp_packet_fragmenter_checker #(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // [7:0] data_byte, [20:8] msg_length, [23:21] zero
    input  logic [mpf_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [0] first_byte
    input  logic                          i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] out_byte
    input  logic [mpf_pkg::M_DATA_W-1:0]  i_m_tdata,
    // [0] packet_start, [1] packet_end
    input  logic [mpf_pkg::M_USER_W-1:0]  i_m_tuser,
    input  logic                          i_m_tlast,
    input  logic                          i_cfg_wr_en,
    input  logic [mpf_pkg::MP_W-1:0]      i_cfg_wr_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       pkt_start;
        logic       pkt_end;
        logic       run_last;
    } t_frag_beat;

    t_frag_beat                  frag_q[$];
    logic [7:0]                  hdr_copy [mpf_pkg::HDR_BYTES];
    logic [mpf_pkg::LEN_W-1:0]   msg_pos;
    logic [mpf_pkg::LEN_W-1:0]   body_len;
    logic [mpf_pkg::LEN_W-1:0]   pkt_count;
    logic [7:0]                  pkt_fill;
    logic                        msg_open;
    logic [mpf_pkg::MP_W-1:0]    pkt_limit;
    int                          fail_total = 0;
    int                          pending_beats = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_beats;

    function automatic void push_beat(input logic [7:0] b, input logic st, input logic en,
                                      input logic last);
        t_frag_beat beat;
        beat.out_byte  = b;
        beat.pkt_start = st;
        beat.pkt_end   = en;
        beat.run_last  = last;
        frag_q.push_back(beat);
    endfunction

    task automatic predict_fragments(input logic [7:0] data, input logic first,
                                     input logic [mpf_pkg::LEN_W-1:0] len);
        int         pos;
        int         left;
        int         mp_eff;
        logic       last_of_msg;
        logic       last_of_pkt;
        logic       som;
        logic       eom;
        logic [7:0] ctrl;
        mp_eff = (pkt_limit == 0) ? 1 : int'(pkt_limit);
        if (first) begin
            msg_pos  = '0;
            pkt_count = '0;
            pkt_fill = '0;
            body_len = '0;
            msg_open = 1'b0;
            if (len > mpf_pkg::HDR_BYTES &&
                int'(len) - mpf_pkg::HDR_BYTES <= MAX_PAYLOAD_BYTES) begin
                body_len = len - mpf_pkg::LEN_W'(mpf_pkg::HDR_BYTES);
                msg_open = 1'b1;
            end
        end
        if (msg_open) begin
            if (msg_pos < mpf_pkg::HDR_BYTES) begin
                hdr_copy[msg_pos[1:0]] = data;
                msg_pos = msg_pos + 1'b1;
            end else begin
                pos = int'(msg_pos) - mpf_pkg::HDR_BYTES;
                last_of_msg = (pos + 1 >= int'(body_len));
                if (pkt_fill == 0) begin
                    left = int'(body_len) - pos;
                    som  = (pkt_count == 0);
                    eom  = (left <= mp_eff);
                    ctrl = {som, eom, pkt_count[1:0], hdr_copy[3][3:0]};
                    push_beat(hdr_copy[0], 1'b1, 1'b0, 1'b0);
                    push_beat(hdr_copy[1], 1'b0, 1'b0, 1'b0);
                    push_beat(hdr_copy[2], 1'b0, 1'b0, 1'b0);
                    push_beat(ctrl, 1'b0, 1'b0, 1'b0);
                end
                pkt_fill = pkt_fill + 1'b1;
                last_of_pkt = last_of_msg || (int'(pkt_fill) >= mp_eff);
                push_beat(data, 1'b0, last_of_pkt, 1'b1);
                if (last_of_pkt) begin
                    pkt_fill  = '0;
                    pkt_count = pkt_count + 1'b1;
                end
                msg_pos = msg_pos + 1'b1;
                if (last_of_msg) begin
                    msg_open = 1'b0;
                end
            end
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_frag_beat want;
        if (!i_rst_n) begin
            frag_q.delete();
            for (int k = 0; k < mpf_pkg::HDR_BYTES; k++) begin
                hdr_copy[k] = '0;
            end
            msg_pos   = '0;
            body_len  = '0;
            pkt_count = '0;
            pkt_fill  = '0;
            msg_open  = 1'b0;
            pkt_limit = mpf_pkg::MP_RESET;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_fragments(i_s_tdata[7:0], i_s_tuser, i_s_tdata[8 +: mpf_pkg::LEN_W]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (frag_q.size() == 0) begin
                    $error("Unexpected output beat: out_byte %0h, tuser %0h, tlast %0b.",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    fail_total++;
                end else begin
                    want = frag_q.pop_front();
                    check_field("out_byte", want.out_byte, i_m_tdata);
                    check_field("packet_start", want.pkt_start, i_m_tuser[0]);
                    check_field("packet_end", want.pkt_end, i_m_tuser[1]);
                    check_field("run_last", want.run_last, i_m_tlast);
                end
            end
            if (i_cfg_wr_en) begin
                pkt_limit = i_cfg_wr_data;
            end
        end
        pending_beats = frag_q.size();
    end

endmodule

/* tb/mctp_packet_fragmenter_top_test.sv */
// ----------------------------------------------------------------------------
// MCTP fragmenter testbench
// Sends directed and random MCTP messages through the fragmenter under random
// idling on both streams, changes the payload limit between phases and in the
// middle of messages, and lets the checker compare every output beat.
// ----------------------------------------------------------------------------
module mctp_packet_fragmenter_top_test;

    localparam int MAX_PAYLOAD_BYTES = 4096;
    localparam int SETTLE_CYCLES     = 10;
    localparam int HOLD_CYCLES       = 300;
    localparam int TARGET_ITEMS      = 460;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [mpf_pkg::S_DATA_W-1:0]   i_s_tdata;
    logic                           i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [mpf_pkg::M_DATA_W-1:0]   o_m_tdata;
    logic [mpf_pkg::M_USER_W-1:0]   o_m_tuser;
    logic                           o_m_tlast;
    logic                           i_cfg_wr_en;
    logic [mpf_pkg::MP_W-1:0]       i_cfg_wr_data;

    int fail_count;
    int pending;
    int items_sent = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    bit hold_req   = 1'b0;

    mctp_packet_fragmenter_top #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    mctp_packet_fragmenter_checker #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [mpf_pkg::MP_W-1:0] pick_pkt_limit();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd1;
            end
            2: begin
                return 8'd255;
            end
            3: begin
                return mpf_pkg::MP_RESET;
            end
            4: begin
                return 8'($urandom_range(17, 254));
            end
            default: begin
                return 8'($urandom_range(2, 16));
            end
        endcase
    endfunction

    // The receiver stalls at random and once holds off for a long stretch on request.
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = rx_gaps_on ? pick_gap() : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    task automatic send_beat(input logic [7:0] data, input logic first,
                             input logic [mpf_pkg::LEN_W-1:0] len);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, len, data};
        i_s_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pkt_limit(input logic [mpf_pkg::MP_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // A negative fill sends random bytes; otherwise every byte carries the fill value.
    task automatic send_message(input int len, input int nbytes, input int split_at,
                                input int fill);
        int         k;
        logic [7:0] data;
        for (k = 0; k < nbytes; k++) begin
            if (split_at > 0 && k == split_at) begin
                settle();
                write_pkt_limit(pick_pkt_limit());
            end
            data = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (k == 0) begin
                send_beat(data, 1'b1, mpf_pkg::LEN_W'(len));
            end else begin
                send_beat(data, 1'b0, mpf_pkg::LEN_W'($urandom_range(0, 8191)));
            end
        end
    endtask

    task automatic send_random_message();
        int r;
        int payload;
        int split;
        r = $urandom_range(0, 99);
        payload = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        if (r < 75) begin
            split = ($urandom_range(0, 6) == 0) ? $urandom_range(1, payload + 3) : 0;
            send_message(payload + 4, payload + 4, split, -1);
        end else if (r < 83) begin
            send_message(payload + 4, $urandom_range(1, payload + 3), 0, -1);
        end else if (r < 88) begin
            send_message(payload + 4, payload + 4 + $urandom_range(1, 3), 0, -1);
        end else if (r < 92) begin
            send_message($urandom_range(0, 4), $urandom_range(1, 5), 0, -1);
        end else if (r < 96) begin
            send_message($urandom_range(4101, 8191), $urandom_range(1, 6), 0, -1);
        end else begin
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0,
                                                     mpf_pkg::LEN_W'($urandom_range(0, 8191)));
        end
    endtask

    initial begin
        int phase;
        i_rst_n       <= 1'b0;
        i_s_tvalid    <= 1'b0;
        i_s_tdata     <= '0;
        i_s_tuser     <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(8'hA5, 1'b0, mpf_pkg::LEN_W'(5));
        send_message(0, 1, 0, -1);
        send_message(4, 4, 0, -1);
        send_message(5, 5, 0, 8'hFF);
        send_message(4101, 2, 0, -1);
        send_message(4100, 6, 0, -1);
        send_message(8191, 1, 0, -1);
        send_message(6, 6, 0, 8'h00);
        send_beat(8'h5A, 1'b0, mpf_pkg::LEN_W'(6));
        send_message(24, 7, 0, -1);
        send_message(6, 6, 0, -1);

        settle();
        write_pkt_limit(8'd0);
        send_message(7, 7, 0, -1);
        settle();
        write_pkt_limit(8'd1);
        send_message(10, 10, 0, -1);
        settle();
        write_pkt_limit(8'd255);
        hold_req = 1'b1;
        send_message(4 + 260, 4 + 260, 0, -1);

        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            settle();
            write_pkt_limit(pick_pkt_limit());
            tx_gaps_on = (phase % 4 != 1);
            rx_gaps_on = (phase % 5 != 2);
            repeat ($urandom_range(1, 4)) begin
                if (items_sent < TARGET_ITEMS) begin
                    send_random_message();
                end
            end
            phase++;
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
